// File: hw/rtl/afp_pkg.sv
// afp_pkg: shared widths, codes and structs of the ack frame parser
// used by every module of the parser and by its checker; no dependencies

package afp_pkg;

    localparam int VAL_W  = 62;
    localparam int KIND_W = 3;
    localparam int ERR_W  = 2;
    localparam int LEFT_W = 3;

    // stream widths (tdata padded to whole bytes)
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 128;
    localparam int M_USER_W = KIND_W;

    // frame type bytes
    localparam logic [7:0] TYPE_ACK     = 8'h02;
    localparam logic [7:0] TYPE_ACK_ECN = 8'h03;

    // result kinds
    localparam logic [KIND_W-1:0] K_BLOCK = 3'd0;
    localparam logic [KIND_W-1:0] K_DELAY = 3'd1;
    localparam logic [KIND_W-1:0] K_ECT0  = 3'd2;
    localparam logic [KIND_W-1:0] K_ECT1  = 3'd3;
    localparam logic [KIND_W-1:0] K_CE    = 3'd4;
    localparam logic [KIND_W-1:0] K_ERROR = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] E_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] E_BAD_TYPE  = 2'd1;
    localparam logic [ERR_W-1:0] E_UNDERFLOW = 2'd2;

    // one decoded variable-length integer
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_field;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value_a;
        logic [VAL_W-1:0]  value_b;
        logic              end_of_frame;
        logic [ERR_W-1:0]  error_code;
    } t_result;

endpackage

// File: hw/rtl/afp_varint.sv
// afp_varint: assembles one quic variable-length integer from bytes
// depends on afp_pkg

module afp_varint (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output afp_pkg::t_field       o_field
);

    logic [afp_pkg::VAL_W-1:0]  r_acc;
    logic [afp_pkg::LEFT_W-1:0] r_left;
    logic                       r_in_varint;

    logic [afp_pkg::VAL_W-1:0]  n_acc;
    logic [afp_pkg::LEFT_W-1:0] n_left;

    // first byte carries the length prefix, later bytes shift in
    always_comb begin
        if (!r_in_varint) begin
            n_acc = {{(afp_pkg::VAL_W-6){1'b0}}, i_byte[5:0]};
            case (i_byte[7:6])
                2'd0:    n_left = 3'd0;
                2'd1:    n_left = 3'd1;
                2'd2:    n_left = 3'd3;
                default: n_left = 3'd7;
            endcase
        end else begin
            n_acc  = {r_acc[afp_pkg::VAL_W-9:0], i_byte};
            n_left = r_left - 3'd1;
        end
    end

    assign o_field.done  = (n_left == 3'd0);
    assign o_field.value = n_acc;

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc       <= '0;
            r_left      <= '0;
            r_in_varint <= 1'b0;
        end else if (i_step) begin
            r_acc       <= n_acc;
            r_left      <= n_left;
            r_in_varint <= (n_left != 3'd0);
        end
    end

endmodule

// File: hw/rtl/afp_decode.sv
// afp_decode: frame phase sequencer, block arithmetic and result build
// depends on afp_pkg; takes finished fields from afp_varint

module afp_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_start,
    input  logic [7:0]            i_byte,
    input  afp_pkg::t_field       i_field,
    output logic                  o_active,
    output logic                  o_res_valid,
    output afp_pkg::t_result      o_res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_LARGEST = 4'd1;
    localparam logic [3:0] PH_DELAY   = 4'd2;
    localparam logic [3:0] PH_COUNT   = 4'd3;
    localparam logic [3:0] PH_FIRST   = 4'd4;
    localparam logic [3:0] PH_GAP     = 4'd5;
    localparam logic [3:0] PH_RANGE   = 4'd6;
    localparam logic [3:0] PH_ECT0    = 4'd7;
    localparam logic [3:0] PH_ECT1    = 4'd8;
    localparam logic [3:0] PH_CE      = 4'd9;
    localparam logic [3:0] PH_SKIP    = 4'd10;

    localparam int VW = afp_pkg::VAL_W;

    logic [3:0]    r_phase,    n_phase;
    logic          r_has_ecn,  n_has_ecn;
    logic [VW-1:0] r_largest,  n_largest;
    logic [VW-1:0] r_smallest, n_smallest;
    logic [VW-1:0] r_ranges,   n_ranges;
    logic [VW-1:0] r_next_lg,  n_next_lg;
    logic          r_gap_uf,   n_gap_uf;

    logic [VW-1:0] v;
    logic [VW-1:0] blk_top;
    logic [VW:0]   blk_diff;
    logic [VW+1:0] gap_diff;
    logic [VW-1:0] ranges_dec;
    logic          last_range;

    assign v        = i_field.value;
    assign o_active = (r_phase != PH_IDLE) && (r_phase != PH_SKIP);

    // one shared subtract gives the block's smallest and its underflow
    assign blk_top    = (r_phase == PH_RANGE) ? r_next_lg : r_largest;
    assign blk_diff   = {1'b0, blk_top} - {1'b0, v};
    // next block's largest, worked out as soon as the gap arrives
    assign gap_diff   = {2'b00, r_smallest} - {2'b00, v} - {{VW{1'b0}}, 2'd2};
    assign ranges_dec = r_ranges - {{(VW-1){1'b0}}, 1'b1};
    assign last_range = (r_ranges == {{(VW-1){1'b0}}, 1'b1});

    // phase sequencing and result build
    always_comb begin
        n_phase     = r_phase;
        n_has_ecn   = r_has_ecn;
        n_largest   = r_largest;
        n_smallest  = r_smallest;
        n_ranges    = r_ranges;
        n_next_lg   = r_next_lg;
        n_gap_uf    = r_gap_uf;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire && i_start) begin
            if (i_byte == afp_pkg::TYPE_ACK || i_byte == afp_pkg::TYPE_ACK_ECN) begin
                n_has_ecn = (i_byte == afp_pkg::TYPE_ACK_ECN);
                n_phase   = PH_LARGEST;
            end else begin
                n_has_ecn          = 1'b0;
                n_phase            = PH_SKIP;
                o_res_valid        = 1'b1;
                o_res.kind         = afp_pkg::K_ERROR;
                o_res.end_of_frame = 1'b1;
                o_res.error_code   = afp_pkg::E_BAD_TYPE;
            end
        end else if (i_fire && o_active && i_field.done) begin
            case (r_phase)
                PH_LARGEST: begin
                    n_largest = v;
                    n_phase   = PH_DELAY;
                end
                PH_DELAY: begin
                    n_phase       = PH_COUNT;
                    o_res_valid   = 1'b1;
                    o_res.kind    = afp_pkg::K_DELAY;
                    o_res.value_a = v;
                end
                PH_COUNT: begin
                    n_ranges = v;
                    n_phase  = PH_FIRST;
                end
                PH_FIRST: begin
                    o_res_valid = 1'b1;
                    if (blk_diff[VW]) begin
                        n_phase            = PH_SKIP;
                        o_res.kind         = afp_pkg::K_ERROR;
                        o_res.end_of_frame = 1'b1;
                        o_res.error_code   = afp_pkg::E_UNDERFLOW;
                    end else begin
                        n_smallest         = blk_diff[VW-1:0];
                        o_res.kind         = afp_pkg::K_BLOCK;
                        o_res.value_a      = r_largest;
                        o_res.value_b      = blk_diff[VW-1:0];
                        o_res.end_of_frame = (r_ranges == '0) && !r_has_ecn;
                        if (r_ranges != '0) begin
                            n_phase = PH_GAP;
                        end else if (r_has_ecn) begin
                            n_phase = PH_ECT0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_GAP: begin
                    n_next_lg = gap_diff[VW-1:0];
                    n_gap_uf  = gap_diff[VW+1];
                    n_phase   = PH_RANGE;
                end
                PH_RANGE: begin
                    o_res_valid = 1'b1;
                    if (r_gap_uf || blk_diff[VW]) begin
                        n_phase            = PH_SKIP;
                        o_res.kind         = afp_pkg::K_ERROR;
                        o_res.end_of_frame = 1'b1;
                        o_res.error_code   = afp_pkg::E_UNDERFLOW;
                    end else begin
                        n_ranges           = ranges_dec;
                        n_smallest         = blk_diff[VW-1:0];
                        o_res.kind         = afp_pkg::K_BLOCK;
                        o_res.value_a      = r_next_lg;
                        o_res.value_b      = blk_diff[VW-1:0];
                        o_res.end_of_frame = last_range && !r_has_ecn;
                        if (!last_range) begin
                            n_phase = PH_GAP;
                        end else if (r_has_ecn) begin
                            n_phase = PH_ECT0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_ECT0: begin
                    n_phase       = PH_ECT1;
                    o_res_valid   = 1'b1;
                    o_res.kind    = afp_pkg::K_ECT0;
                    o_res.value_a = v;
                end
                PH_ECT1: begin
                    n_phase       = PH_CE;
                    o_res_valid   = 1'b1;
                    o_res.kind    = afp_pkg::K_ECT1;
                    o_res.value_a = v;
                end
                PH_CE: begin
                    n_phase            = PH_IDLE;
                    o_res_valid        = 1'b1;
                    o_res.kind         = afp_pkg::K_CE;
                    o_res.value_a      = v;
                    o_res.end_of_frame = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_has_ecn  <= 1'b0;
            r_largest  <= '0;
            r_smallest <= '0;
            r_ranges   <= '0;
            r_next_lg  <= '0;
            r_gap_uf   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_has_ecn  <= n_has_ecn;
            r_largest  <= n_largest;
            r_smallest <= n_smallest;
            r_ranges   <= n_ranges;
            r_next_lg  <= n_next_lg;
            r_gap_uf   <= n_gap_uf;
        end
    end

endmodule

// File: hw/rtl/afp_out_buf.sv
// afp_out_buf: result register with a skid stage behind it
// depends on afp_pkg

module afp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  afp_pkg::t_result      i_res,
    input  logic                  i_ready,
    output logic                  o_valid,
    output afp_pkg::t_result      o_res,
    output logic                  o_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    afp_pkg::t_result r_out;
    afp_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_out_valid && i_ready;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_ready = !r_skid_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

// File: hw/rtl/ack_frame_parser.sv
// ack_frame_parser: one byte a cycle, ack delay, blocks, ecn counts and
// error words out, each through the result register (skid when stalled)
// throughput: one byte per cycle; s_axis_tready drops only while both the
// result register and the skid stage hold words
// reset (synchronous, active low): parser idle, all buffers empty
// depends on afp_pkg, afp_varint, afp_decode, afp_out_buf

module ack_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [afp_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic [afp_pkg::S_USER_W-1:0]  s_axis_tuser,  // [0] frame_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [61:0] value_a, [123:62] value_b, [125:124] error_code, [127:126] zero
    output logic [afp_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic [afp_pkg::M_USER_W-1:0]  m_axis_tuser,  // [2:0] kind
    output logic                          m_axis_tlast   // end_of_frame
);

    logic             fire;
    logic             active;
    logic             res_valid;
    afp_pkg::t_field  field;
    afp_pkg::t_result res;
    afp_pkg::t_result out_res;

    assign fire = s_axis_tvalid && s_axis_tready;

    // field assembly
    afp_varint u_varint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (fire && s_axis_tuser[0]),
        .i_step  (fire && !s_axis_tuser[0] && active),
        .i_byte  (s_axis_tdata),
        .o_field (field)
    );

    // frame sequencing
    afp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_start     (s_axis_tuser[0]),
        .i_byte      (s_axis_tdata),
        .i_field     (field),
        .o_active    (active),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register and skid
    afp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .o_ready (s_axis_tready)
    );

    // output packing
    assign m_axis_tdata = {2'b00, out_res.error_code, out_res.value_b, out_res.value_a};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.end_of_frame;

endmodule

// File: hw/rtl/afp_checker.sv
// afp_checker: port-level assertions for ack_frame_parser, bound to the top
// depends on afp_pkg and ack_frame_parser

module afp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [afp_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic [afp_pkg::S_USER_W-1:0]  s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [afp_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic [afp_pkg::M_USER_W-1:0]  m_axis_tuser,
    input  logic                          m_axis_tlast
);

    // a stalled word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // input backpressure only with a word waiting on the output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // error words end the frame and carry a code and no values
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == afp_pkg::K_ERROR |->
            m_axis_tlast && m_axis_tdata[125:124] != afp_pkg::E_NONE
            && m_axis_tdata[123:0] == '0)
        else $error("malformed error word");

    // other words carry no error code and a known kind
    a_plain_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != afp_pkg::K_ERROR |->
            m_axis_tdata[125:124] == afp_pkg::E_NONE && m_axis_tuser <= afp_pkg::K_CE)
        else $error("error code or kind out of place");

endmodule

bind ack_frame_parser afp_checker u_afp_checker (.*);

// File: sim/tb.sv
// tb: self-checking bench for ack_frame_parser, byte stream in, result words out
// drives ack frames (directed, then random well-formed, broken and noise) and
// checks every result word against a cycle-free model of the parser; uses afp_pkg

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afp_pkg::*;

    localparam logic [VAL_W-1:0] PN_MAX = '1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [3:0] {
        P_IDLE, P_LARGEST, P_DELAY, P_COUNT, P_FIRST, P_GAP, P_RANGE,
        P_ECT0, P_ECT1, P_CE, P_SKIP
    } t_parse_phase;

    typedef struct {
        logic [7:0] data_byte;
        logic       frame_start;
        bit         pause;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // [7:0] data_byte
    logic [S_USER_W-1:0] s_axis_tuser = '0;   // [0] frame_start
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [61:0] value_a, [123:62] value_b, [125:124] error_code, [127:126] zero
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;        // [2:0] kind
    logic m_axis_tlast;                       // end_of_frame

    ack_frame_parser dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // parser model state
    t_parse_phase     ph = P_IDLE;
    logic [VAL_W-1:0] acc = '0;
    logic [2:0]       bytes_left = '0;
    logic             ecn_on = 1'b0;
    logic [VAL_W-1:0] largest_pn = '0;
    logic [VAL_W-1:0] smallest_pn = '0;
    logic [VAL_W-1:0] ranges_rem = '0;
    logic [VAL_W-1:0] gap_hold = '0;
    bit               mid_field = 1'b0;

    t_result   ack_results_q[$];
    t_byte_item frame_bytes_q[$];

    int  n_fail = 0;
    int  n_results = 0;
    int  n_gen = 0;
    int  cycle_cnt = 0;
    int  trunc_left = -1;
    bit  counting = 1'b1;
    bit  stim_done = 1'b0;
    bit  word_taken = 1'b0;

    task automatic push_result(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] a,
                               input logic [VAL_W-1:0] b, input logic eof,
                               input logic [ERR_W-1:0] err);
        t_result r;
        r.kind = kind;
        r.value_a = a;
        r.value_b = b;
        r.end_of_frame = eof;
        r.error_code = err;
        ack_results_q.push_back(r);
    endtask

    task automatic raise_error(input logic [ERR_W-1:0] err);
        ph = P_SKIP;
        push_result(K_ERROR, '0, '0, 1'b1, err);
    endtask

    // one acknowledged block, then on to the next pair, the ecn counts or idle
    task automatic give_block(input logic [VAL_W-1:0] lg, input logic [VAL_W-1:0] sm);
        logic eof;
        eof = (ranges_rem == 0) && !ecn_on;
        smallest_pn = sm;
        if (ranges_rem != 0)
            ph = P_GAP;
        else if (ecn_on)
            ph = P_ECT0;
        else
            ph = P_IDLE;
        push_result(K_BLOCK, lg, sm, eof, E_NONE);
    endtask

    task automatic field_complete(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] lg;
        case (ph)
            P_LARGEST: begin
                largest_pn = v;
                ph = P_DELAY;
            end
            P_DELAY: begin
                ph = P_COUNT;
                push_result(K_DELAY, v, '0, 1'b0, E_NONE);
            end
            P_COUNT: begin
                ranges_rem = v;
                ph = P_FIRST;
            end
            P_FIRST: begin
                if (v > largest_pn)
                    raise_error(E_UNDERFLOW);
                else
                    give_block(largest_pn, largest_pn - v);
            end
            P_GAP: begin
                gap_hold = v;
                ph = P_RANGE;
            end
            P_RANGE: begin
                if (smallest_pn < 2 || gap_hold > smallest_pn - 2) begin
                    raise_error(E_UNDERFLOW);
                end else begin
                    lg = smallest_pn - gap_hold - 2;
                    if (v > lg) begin
                        raise_error(E_UNDERFLOW);
                    end else begin
                        ranges_rem = ranges_rem - 1;
                        give_block(lg, lg - v);
                    end
                end
            end
            P_ECT0: begin
                ph = P_ECT1;
                push_result(K_ECT0, v, '0, 1'b0, E_NONE);
            end
            P_ECT1: begin
                ph = P_CE;
                push_result(K_ECT1, v, '0, 1'b0, E_NONE);
            end
            P_CE: begin
                ph = P_IDLE;
                push_result(K_CE, v, '0, 1'b1, E_NONE);
            end
            default: ph = P_IDLE;
        endcase
    endtask

    // advance the model by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic st);
        if (st) begin
            acc = '0;
            bytes_left = '0;
            mid_field = 1'b0;
            if (b == TYPE_ACK || b == TYPE_ACK_ECN) begin
                ecn_on = (b == TYPE_ACK_ECN);
                ph = P_LARGEST;
            end else begin
                ecn_on = 1'b0;
                raise_error(E_BAD_TYPE);
            end
            return;
        end
        if (ph == P_IDLE || ph == P_SKIP)
            return;
        // varint: 2-bit length prefix, big-endian value
        if (!mid_field) begin
            acc = {56'b0, b[5:0]};
            bytes_left = 3'((1 << b[7:6]) - 1);
            mid_field = 1'b1;
        end else begin
            acc = {acc[VAL_W-9:0], b};
            bytes_left = bytes_left - 3'd1;
        end
        if (bytes_left != 0)
            return;
        mid_field = 1'b0;
        field_complete(acc);
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    task automatic put_byte(input logic [7:0] b, input logic st);
        t_byte_item it;
        if (trunc_left == 0)
            return;
        if (trunc_left > 0)
            trunc_left--;
        it.data_byte = b;
        it.frame_start = st;
        it.pause = 1'b0;
        frame_bytes_q.push_back(it);
        if (counting)
            n_gen++;
    endtask

    task automatic put_pause();
        t_byte_item it;
        it.data_byte = '0;
        it.frame_start = 1'b0;
        it.pause = 1'b1;
        frame_bytes_q.push_back(it);
    endtask

    // encode with the shortest length or, half the time, a random one no shorter
    task automatic put_varint(input logic [VAL_W-1:0] v);
        int code;
        int nb;
        logic [63:0] w;
        if (v < 64'd64)
            code = 0;
        else if (v < 64'd16384)
            code = 1;
        else if (v < 64'd1073741824)
            code = 2;
        else
            code = 3;
        if ($urandom_range(0, 1))
            code = $urandom_range(code, 3);
        nb = 1 << code;
        w = {2'b00, v} | (64'(code) << (nb * 8 - 2));
        for (int i = nb - 1; i >= 0; i--)
            put_byte(w[8*i +: 8], 1'b0);
    endtask

    function automatic logic [VAL_W-1:0] pick_pn();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PN_MAX;
            default: return VAL_W'({$urandom, $urandom} >> $urandom_range(2, 63));
        endcase
    endfunction

    // a value in 0..x, leaning to the ends and to small steps
    function automatic logic [VAL_W-1:0] pick_upto(input logic [VAL_W-1:0] x);
        logic [63:0] r;
        logic [63:0] span;
        r = {$urandom, $urandom};
        span = {2'b00, x} + 64'd1;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return x;
            2, 3: return VAL_W'(r % ((span < 64'd64) ? span : 64'd64));
            default: return VAL_W'(r % span);
        endcase
    endfunction

    // one ack frame, sometimes with an underflow or a count left open
    task automatic gen_frame();
        logic [VAL_W-1:0] lg_top;
        logic [VAL_W-1:0] sm;
        logic [VAL_W-1:0] lg;
        logic [VAL_W-1:0] gap_v;
        logic [VAL_W-1:0] rng;
        logic [VAL_W-1:0] count_out;
        logic [VAL_W-1:0] fields_q[$];
        int target;
        int inj;
        int inj_k;
        int npairs;
        bit failed;
        bit with_ecn;

        with_ecn = $urandom_range(0, 1);
        lg_top = pick_pn();
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        case ($urandom_range(0, 9))
            0: inj = 1;
            1: inj = 2;
            2: inj = 3;
            default: inj = 0;
        endcase
        if (inj >= 2 && target == 0)
            inj = 0;
        if (inj == 1 && lg_top == PN_MAX)
            inj = 0;
        inj_k = (target > 0) ? $urandom_range(0, target - 1) : 0;
        failed = 1'b0;
        npairs = 0;

        if (inj == 1) begin
            fields_q.push_back(lg_top + 1);
            failed = 1'b1;
        end else begin
            rng = pick_upto(lg_top);
            sm = lg_top - rng;
            fields_q.push_back(rng);
            for (int k = 0; k < target && !failed; k++) begin
                if (inj == 2 && k == inj_k) begin
                    // gap past zero, then any range to close the pair
                    fields_q.push_back((sm >= 2) ? sm - 1 : pick_pn());
                    fields_q.push_back(pick_pn());
                    failed = 1'b1;
                end else if (sm < 2) begin
                    break;
                end else begin
                    gap_v = pick_upto(sm - 2);
                    lg = sm - gap_v - 2;
                    fields_q.push_back(gap_v);
                    if (inj == 3 && k == inj_k && lg != PN_MAX) begin
                        fields_q.push_back(lg + 1);
                        failed = 1'b1;
                    end else begin
                        rng = pick_upto(lg);
                        sm = lg - rng;
                        fields_q.push_back(rng);
                        npairs++;
                    end
                end
            end
        end

        count_out = failed ? VAL_W'(target) : VAL_W'(npairs);
        if (!failed && $urandom_range(0, 19) == 0)
            count_out = count_out + VAL_W'($urandom_range(1, 5));

        put_byte(with_ecn ? TYPE_ACK_ECN : TYPE_ACK, 1'b1);
        put_varint(lg_top);
        put_varint(pick_pn());
        put_varint(count_out);
        foreach (fields_q[i])
            put_varint(fields_q[i]);
        if (!failed && with_ecn) begin
            put_varint(pick_pn());
            put_varint(pick_pn());
            put_varint(pick_pn());
        end
    endtask

    task automatic build_stimulus();
        int r;
        logic [7:0] bad;

        // directed: stray byte, bad type, skip, ecn frame, underflows, cut frame
        put_byte(8'hFF, 1'b0);
        put_byte(8'h07, 1'b1);
        put_byte(8'h02, 1'b0);
        put_byte(TYPE_ACK_ECN, 1'b1);
        put_byte(8'h0A, 1'b0);          // largest 10
        put_byte(8'h00, 1'b0);          // delay 0
        put_byte(8'h01, 1'b0);          // one pair
        put_byte(8'h02, 1'b0);          // block 10..8
        put_byte(8'h05, 1'b0);          // gap 5
        put_byte(8'h01, 1'b0);          // block 1..0
        put_byte(8'h00, 1'b0);          // ect0 0
        put_byte(8'h3F, 1'b0);          // ect1 63
        put_byte(8'h40, 1'b0);          // ce 0, two-byte form
        put_byte(8'h00, 1'b0);
        // first range above largest
        put_byte(TYPE_ACK, 1'b1);
        put_byte(8'h05, 1'b0);
        put_byte(8'h3F, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h06, 1'b0);
        // gap below zero
        put_byte(TYPE_ACK, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);          // range closing the pair
        // huge range count cut off by a new frame start
        put_byte(TYPE_ACK, 1'b1);
        put_byte(8'h10, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hBF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(TYPE_ACK_ECN, 1'b1);
        put_pause();

        // random mix of frames, truncated frames, bad types, noise and pauses
        while (n_gen < 1500) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                gen_frame();
            end else if (r < 82) begin
                trunc_left = $urandom_range(1, 10);
                gen_frame();
                trunc_left = -1;
            end else if (r < 90) begin
                do bad = 8'($urandom); while (bad == TYPE_ACK || bad == TYPE_ACK_ECN);
                put_byte(bad, 1'b1);
                counting = 1'b0;
                repeat ($urandom_range(0, 4)) put_byte(8'($urandom), 1'b0);
                counting = 1'b1;
            end else if (r < 97) begin
                counting = 1'b0;
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'b0);
                counting = 1'b1;
            end else begin
                put_pause();
            end
        end
    endtask

    // idle lengths: mostly short, a few long, none while quiet
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // byte driver: next word at the falling edge once the last one was taken
    int  tx_gap = 0;
    bit  tx_quiet = 1'b0;
    t_byte_item tx_item;

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || word_taken)) begin
            if (word_taken) begin
                word_taken = 1'b0;
                if ($urandom_range(0, 99) == 0)
                    tx_quiet = !tx_quiet;
                tx_gap = pick_gap(tx_quiet);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (frame_bytes_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                stim_done = 1'b1;
            end else if (frame_bytes_q[0].pause) begin
                // hold off until every expected word is out
                s_axis_tvalid <= 1'b0;
                if (ack_results_q.size() == 0)
                    void'(frame_bytes_q.pop_front());
            end else begin
                tx_item = frame_bytes_q.pop_front();
                s_axis_tdata <= tx_item.data_byte;
                s_axis_tuser <= tx_item.frame_start;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result receiver: random stalls plus two long hold-offs
    int rx_stall = 0;
    int hold_idx = 0;
    bit rx_quiet = 1'b0;
    int hold_marks[2] = '{150, 700};

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_idx < 2 && n_results >= hold_marks[hold_idx]) begin
                hold_idx++;
                rx_stall = 300;
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    rx_quiet = !rx_quiet;
                if ($urandom_range(0, 3) == 0)
                    rx_stall = pick_gap(rx_quiet);
            end
        end
    end

    // monitor: check result words, then feed accepted bytes to the model
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.value_a = m_axis_tdata[61:0];
                got.value_b = m_axis_tdata[123:62];
                got.error_code = m_axis_tdata[125:124];
                got.end_of_frame = m_axis_tlast;
                n_results++;
                if (ack_results_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected word kind %0d a %h b %h last %b err %0d",
                             $time, got.kind, got.value_a, got.value_b,
                             got.end_of_frame, got.error_code);
                end else begin
                    want = ack_results_q.pop_front();
                    if (got.kind !== want.kind || got.value_a !== want.value_a ||
                        got.value_b !== want.value_b ||
                        got.end_of_frame !== want.end_of_frame ||
                        got.error_code !== want.error_code) begin
                        n_fail++;
                        $display("%0t: expected kind %0d a %h b %h last %b err %0d",
                                 $time, want.kind, want.value_a, want.value_b,
                                 want.end_of_frame, want.error_code);
                        $display("%0t: actual   kind %0d a %h b %h last %b err %0d",
                                 $time, got.kind, got.value_a, got.value_b,
                                 got.end_of_frame, got.error_code);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata, s_axis_tuser[0]);
                word_taken = 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ack_frame_parser verification failed");
            $finish;
        end
    end

    // reset, run, drain
    initial begin
        build_stimulus();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (ack_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("ack_frame_parser verification clean");
        else
            $display("ack_frame_parser verification failed");
        $finish;
    end

endmodule

// File: ack_frame_parser.f
hw/rtl/afp_pkg.sv
hw/rtl/afp_varint.sv
hw/rtl/afp_decode.sv
hw/rtl/afp_out_buf.sv
hw/rtl/ack_frame_parser.sv
hw/rtl/afp_checker.sv
sim/tb.sv
